/* sv/manning_friction_point_implicit_defines.svh */
// ----------------------------------------------------------------------------
// Manning friction assertion macros
// Immediate-consequence and next-cycle property checks, clocked on clk and
// disabled during rst. Define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef MANNING_FRICTION_POINT_IMPLICIT_DEFINES_SVH
`define MANNING_FRICTION_POINT_IMPLICIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define MFPI_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define MFPI_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define MFPI_ASSERT_IMP(lbl, ante, cons, msg)
`define MFPI_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

/* sv/mfpi_pkg.sv */
// ----------------------------------------------------------------------------
// Manning friction package
// Status codes, register indexes, constants and the pipeline stage record.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mfpi_pkg;

  typedef enum logic [1:0] {
    STAT_UPD   = 2'd0,
    STAT_SKIP  = 2'd1,
    STAT_DRY   = 2'd2,
    STAT_STILL = 2'd3
  } stat_t;

  typedef enum logic [1:0] {
    REG_TIME_STEP   = 2'd0,
    REG_SMALL_LIMIT = 2'd1,
    REG_GRID_COLS   = 2'd2,
    REG_GRID_ROWS   = 2'd3
  } reg_t;

  // g = 9.81 in Q16.16
  localparam logic [19:0] GRAV_Q16     = 20'd642908;
  localparam logic [12:0] DOMAIN_RESET = 13'd4096;
  localparam logic [15:0] LIMIT_RESET  = 16'd1;

  typedef struct packed {
    stat_t               st;
    logic signed [31:0]  qx;
    logic signed [31:0]  qy;
    logic [31:0]         ax;
    logic [31:0]         ay;
    logic [31:0]         h;
    logic [31:0]         nn;
    logic [35:0]         t;
    logic [63:0]         axx;
    logic [63:0]         ayy;
    logic [63:0]         s;
    logic [31:0]         sq_r;
    logic [63:0]         sq_r2;
    logic [60:0]         cb_x;
    logic [20:0]         cb_r;
    logic [41:0]         cb_r2;
    logic [62:0]         cb_r3;
    logic [63:0]         ta_lo;
    logic [35:0]         ta_hi;
    logic [74:0]         a;
    logic [31:0]         d1_rem;
    logic [74:0]         d1_q;
    logic [63:0]         rx_rem;
    logic [63:0]         ry_rem;
    logic [32:0]         rx_q;
    logic [32:0]         ry_q;
    logic [52:0]         hc;
    logic [56:0]         pp0;
    logic [56:0]         pp1;
    logic [56:0]         pp2;
    logic [106:0]        p;
    logic                sat;
    logic [52:0]         d2_rem;
    logic [62:0]         d2_n;
    logic [62:0]         d2_q;
    logic [62:0]         w;
    logic [64:0]         wlx;
    logic [64:0]         wly;
    logic [63:0]         whx;
    logic [63:0]         why;
    logic [96:0]         numx;
    logic [96:0]         numy;
    logic [96:0]         denx;
    logic [96:0]         deny;
    logic [96:0]         fx_rem;
    logic [96:0]         fy_rem;
    logic [32:0]         fx_q;
    logic [32:0]         fy_q;
    logic [64:0]         mx;
    logic [64:0]         my;
    logic [31:0]         oqx;
    logic [31:0]         oqy;
  } pl_t;

endpackage

`default_nettype wire

/* sv/mfpi_if.sv */
// ----------------------------------------------------------------------------
// Manning friction channel interfaces
// Valid/ready channels for incoming grid cells and outgoing discharges.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface mfpi_cell_if;
  logic               valid;
  logic               ready;
  logic [11:0]        cell_col;
  logic [11:0]        cell_row;
  logic signed [31:0] surface_level;
  logic signed [31:0] discharge_x;
  logic signed [31:0] discharge_y;
  logic signed [31:0] bed_level;
  logic [15:0]        manning_n;

  modport source (output valid, cell_col, cell_row, surface_level, discharge_x,
                  discharge_y, bed_level, manning_n, input ready);
  modport sink (input valid, cell_col, cell_row, surface_level, discharge_x,
                discharge_y, bed_level, manning_n, output ready);
endinterface

interface mfpi_flow_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] new_discharge_x;
  logic signed [31:0] new_discharge_y;
  mfpi_pkg::stat_t    status;

  modport source (output valid, new_discharge_x, new_discharge_y, status, input ready);
  modport sink (input valid, new_discharge_x, new_discharge_y, status, output ready);
endinterface

`default_nettype wire

/* sv/manning_friction_point_implicit.sv */
// ----------------------------------------------------------------------------
// Point-implicit Manning friction
// Per-cell friction update of x/y unit discharge on a shallow-water grid.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake     Content
// cells     in   valid/ready   column, row, surface, qx, qy, bed, Manning n
// flows     out  valid/ready   new qx, new qy, status
// wr_*      in   write enable  register index, write data
//
// One item per clock. 139 pipeline stages plus the output register. Depth
// is set by the bit-serial units (square root, cube root, the long dividers)
// at one or three quotient bits a stage. Reset clears valid bits and loads
// register defaults. A result that waits goes to a skid register; only
// while that is full does the pipeline stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "manning_friction_point_implicit_defines.svh"

module manning_friction_point_implicit #(
  parameter int MAX_GRID_DIM = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst,
  mfpi_cell_if.sink        cells,
  mfpi_flow_if.source      flows,
  input  wire logic        wr_en,
  input  wire logic [1:0]  wr_index,
  input  wire logic [31:0] wr_data
);

  localparam int K_MUL  = 1;
  localparam int K_SUM  = 2;
  localparam int K_A    = 3;
  localparam int K_CB   = 2;
  localparam int CB_N   = 21;
  localparam int K_SQ   = 3;
  localparam int SQ_N   = 32;
  localparam int K_RD   = 3;
  localparam int RD_N   = 33;
  localparam int K_D1   = 4;
  localparam int D1_PER = 3;
  localparam int D1_N   = 25;
  localparam int K_HC   = K_CB + CB_N;
  localparam int K_PP   = K_SQ + SQ_N;
  localparam int K_P    = K_PP + 1;
  localparam int K_SAT  = K_P + 1;
  localparam int K_D2   = K_SAT + 1;
  localparam int D2_N   = 63;
  localparam int K_W    = K_D2 + D2_N;
  localparam int K_NUM  = K_W + 1;
  localparam int K_DEN  = K_NUM + 1;
  localparam int K_FD   = K_DEN + 1;
  localparam int FD_N   = 33;
  localparam int K_MAG  = K_FD + FD_N;
  localparam int K_OUT  = K_MAG + 1;
  localparam int NST    = K_OUT + 1;

  localparam logic [16:0] GRID_MAX = 17'(MAX_GRID_DIM);

  logic [31:0] time_step;
  logic [15:0] small_limit;
  logic [12:0] grid_cols;
  logic [12:0] grid_rows;

  mfpi_pkg::pl_t    pipe [NST];
  mfpi_pkg::pl_t    s0;
  logic [NST-1:0]   vld;
  logic             en;

  logic             out_vld;
  logic             skid_vld;
  logic [31:0]      ox, oy, sx, sy;
  mfpi_pkg::stat_t  ostat, sstat;

  logic signed [32:0] depth;
  logic [16:0]        cols_eff, rows_eff;
  logic               bnd, dry;

  function automatic logic [64:0] div_step64(input logic [63:0] rem, input logic bin,
                                             input logic [63:0] d);
    logic [64:0] r;
    r = {rem, bin};
    if (r >= {1'b0, d}) return {1'b1, 64'(r - {1'b0, d})};
    return {1'b0, r[63:0]};
  endfunction

  function automatic logic [97:0] div_step97(input logic [96:0] rem, input logic bin,
                                             input logic [96:0] d);
    logic [97:0] r;
    r = {rem, bin};
    if (r >= {1'b0, d}) return {1'b1, 97'(r - {1'b0, d})};
    return {1'b0, r[96:0]};
  endfunction

  function automatic mfpi_pkg::pl_t stage_fn(input int k, input mfpi_pkg::pl_t x,
                                             input logic [31:0] ts, input logic [15:0] sl);
    mfpi_pkg::pl_t y;
    int            b;
    int            j;
    logic [63:0]   c2, c3, t1, t2;
    logic [51:0]   g52;
    logic [32:0]   r33;
    logic [53:0]   r54;
    logic          qb;
    logic [64:0]   sx64, sy64;
    logic [97:0]   fx98, fy98;
    logic [62:0]   wv;
    logic [31:0]   m;
    y = x;
    if (k == K_MUL) begin
      y.axx   = 64'(x.ax) * 64'(x.ax);
      y.ayy   = 64'(x.ay) * 64'(x.ay);
      g52     = 52'(x.nn) * 52'(mfpi_pkg::GRAV_Q16);
      y.t     = g52[51:16];
      y.cb_x  = {x.h, 29'b0};
      y.cb_r  = '0;
      y.cb_r2 = '0;
      y.cb_r3 = '0;
    end
    if (k == K_SUM) begin
      y.s     = x.axx + x.ayy;
      y.ta_lo = 64'(ts) * 64'(x.t[31:0]);
      y.ta_hi = 36'(ts) * 36'(x.t[35:32]);
      y.sq_r  = '0;
      y.sq_r2 = '0;
    end
    if (k == K_A) begin
      y.a      = (75'(x.ta_lo) + (75'(x.ta_hi) << 32)) << 7;
      y.d1_rem = '0;
    end
    if (k >= K_CB && k < K_CB + CB_N) begin
      b  = CB_N - 1 - (k - K_CB);
      t1 = 64'(x.cb_r2) << b;
      t2 = 64'(x.cb_r) << (2 * b);
      c3 = 64'(x.cb_r3) + t1 + (t1 << 1) + t2 + (t2 << 1) + (64'd1 << (3 * b));
      if (c3 <= 64'(x.cb_x)) begin
        y.cb_r  = x.cb_r | (21'd1 << b);
        y.cb_r3 = c3[62:0];
        y.cb_r2 = x.cb_r2 + (42'(x.cb_r) << (b + 1)) + (42'd1 << (2 * b));
      end
    end
    if (k >= K_SQ && k < K_SQ + SQ_N) begin
      b  = SQ_N - 1 - (k - K_SQ);
      c2 = x.sq_r2 + (64'(x.sq_r) << (b + 1)) + (64'd1 << (2 * b));
      if (c2 <= x.s) begin
        y.sq_r  = x.sq_r | (32'd1 << b);
        y.sq_r2 = c2;
      end
    end
    if (k >= K_RD && k < K_RD + RD_N) begin
      j    = k - K_RD;
      sx64 = div_step64((j == 0) ? {1'b0, x.axx[63:1]} : x.rx_rem,
                        (j == 0) && x.axx[0], x.s);
      sy64 = div_step64((j == 0) ? {1'b0, x.ayy[63:1]} : x.ry_rem,
                        (j == 0) && x.ayy[0], x.s);
      y.rx_rem = sx64[63:0];
      y.ry_rem = sy64[63:0];
      y.rx_q   = {x.rx_q[31:0], sx64[64]};
      y.ry_q   = {x.ry_q[31:0], sy64[64]};
    end
    if (k >= K_D1 && k < K_D1 + D1_N) begin
      for (int i = 0; i < D1_PER; i++) begin
        r33 = {y.d1_rem, y.a[74]};
        y.a = y.a << 1;
        qb  = r33 >= {1'b0, y.h};
        if (qb) r33 = r33 - {1'b0, y.h};
        y.d1_rem = r33[31:0];
        y.d1_q   = {y.d1_q[73:0], qb};
      end
    end
    if (k == K_HC) begin
      y.hc = 53'(x.h) * 53'(x.cb_r);
    end
    if (k == K_PP) begin
      if (x.st == mfpi_pkg::STAT_UPD && (x.s == '0 || x.sq_r < 32'(sl)))
        y.st = mfpi_pkg::STAT_STILL;
      y.pp0 = 57'(x.d1_q[24:0]) * 57'(x.sq_r);
      y.pp1 = 57'(x.d1_q[49:25]) * 57'(x.sq_r);
      y.pp2 = 57'(x.d1_q[74:50]) * 57'(x.sq_r);
    end
    if (k == K_P) begin
      y.p = 107'(x.pp0) + (107'(x.pp1) << 25) + (107'(x.pp2) << 50);
    end
    if (k == K_SAT) begin
      y.sat    = 53'(x.p[106:63]) >= x.hc;
      y.d2_rem = 53'(x.p[106:63]);
      y.d2_n   = x.p[62:0];
    end
    if (k >= K_D2 && k < K_D2 + D2_N) begin
      r54 = {x.d2_rem, x.d2_n[62]};
      qb  = r54 >= {1'b0, x.hc};
      if (qb) r54 = r54 - {1'b0, x.hc};
      y.d2_rem = r54[52:0];
      y.d2_n   = x.d2_n << 1;
      y.d2_q   = {x.d2_q[61:0], qb};
    end
    if (k == K_W) begin
      wv    = x.sat ? {63{1'b1}} : x.d2_q;
      y.w   = wv;
      y.wlx = 65'(wv[31:0]) * 65'(x.rx_q);
      y.wly = 65'(wv[31:0]) * 65'(x.ry_q);
      y.whx = 64'(wv[62:32]) * 64'(x.rx_q);
      y.why = 64'(wv[62:32]) * 64'(x.ry_q);
    end
    if (k == K_NUM) begin
      y.numx = 97'(x.wlx) + (97'(x.whx) << 32) + (97'd1 << 64);
      y.numy = 97'(x.wly) + (97'(x.why) << 32) + (97'd1 << 64);
    end
    if (k == K_DEN) begin
      y.denx = x.numx + (97'(x.w) << 32);
      y.deny = x.numy + (97'(x.w) << 32);
    end
    if (k >= K_FD && k < K_FD + FD_N) begin
      j    = k - K_FD;
      fx98 = div_step97((j == 0) ? {1'b0, x.numx[96:1]} : x.fx_rem,
                        (j == 0) && x.numx[0], x.denx);
      fy98 = div_step97((j == 0) ? {1'b0, x.numy[96:1]} : x.fy_rem,
                        (j == 0) && x.numy[0], x.deny);
      y.fx_rem = fx98[96:0];
      y.fy_rem = fy98[96:0];
      y.fx_q   = {x.fx_q[31:0], fx98[97]};
      y.fy_q   = {x.fy_q[31:0], fy98[97]};
    end
    if (k == K_MAG) begin
      y.mx = 65'(x.ax) * 65'(x.fx_q);
      y.my = 65'(x.ay) * 65'(x.fy_q);
    end
    if (k == K_OUT) begin
      m     = x.mx[63:32];
      y.oqx = (x.st != mfpi_pkg::STAT_UPD) ? $unsigned(x.qx) : (x.qx[31] ? -m : m);
      m     = x.my[63:32];
      y.oqy = (x.st != mfpi_pkg::STAT_UPD) ? $unsigned(x.qy) : (x.qy[31] ? -m : m);
    end
    return y;
  endfunction

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      time_step   <= '0;
      small_limit <= mfpi_pkg::LIMIT_RESET;
      grid_cols   <= mfpi_pkg::DOMAIN_RESET;
      grid_rows   <= mfpi_pkg::DOMAIN_RESET;
    end else if (wr_en) begin
      case (wr_index)
        mfpi_pkg::REG_TIME_STEP:   time_step   <= wr_data;
        mfpi_pkg::REG_SMALL_LIMIT: small_limit <= wr_data[15:0];
        mfpi_pkg::REG_GRID_COLS:   grid_cols   <= wr_data[12:0];
        mfpi_pkg::REG_GRID_ROWS:   grid_rows   <= wr_data[12:0];
        default: ;
      endcase
    end
  end

  // entry stage: border, dry test, magnitudes
  always_comb begin
    cols_eff = (17'(grid_cols) > GRID_MAX) ? GRID_MAX : 17'(grid_cols);
    rows_eff = (17'(grid_rows) > GRID_MAX) ? GRID_MAX : 17'(grid_rows);
    depth    = {cells.surface_level[31], cells.surface_level}
             - {cells.bed_level[31], cells.bed_level};
    bnd = (cells.cell_col == '0) || (cells.cell_row == '0)
       || ((17'(cells.cell_col) + 17'd1) >= cols_eff)
       || ((17'(cells.cell_row) + 17'd1) >= rows_eff)
       || (time_step == '0);
    dry = (depth <= 33'sd0) || (depth < $signed(33'(small_limit)));
    s0    = '0;
    s0.st = bnd ? mfpi_pkg::STAT_SKIP : (dry ? mfpi_pkg::STAT_DRY : mfpi_pkg::STAT_UPD);
    s0.qx = cells.discharge_x;
    s0.qy = cells.discharge_y;
    s0.ax = cells.discharge_x[31] ? 32'(-cells.discharge_x) : $unsigned(cells.discharge_x);
    s0.ay = cells.discharge_y[31] ? 32'(-cells.discharge_y) : $unsigned(cells.discharge_y);
    s0.h  = depth[31:0];
    s0.nn = 32'(cells.manning_n) * 32'(cells.manning_n);
  end

  assign en          = !skid_vld;
  assign cells.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NST-2:0], cells.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) pipe[0] <= s0;
  end

  for (genvar k = 1; k < NST; k++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en) pipe[k] <= stage_fn(k, pipe[k-1], time_step, small_limit);
    end
  end

  // output register with skid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld  <= 1'b0;
      skid_vld <= 1'b0;
    end else if (en) begin
      if (vld[NST-1]) begin
        if (!out_vld || flows.ready) out_vld  <= 1'b1;
        else                         skid_vld <= 1'b1;
      end else if (flows.ready) begin
        out_vld <= 1'b0;
      end
    end else if (flows.ready) begin
      skid_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (vld[NST-1]) begin
        if (!out_vld || flows.ready) begin
          ox    <= pipe[NST-1].oqx;
          oy    <= pipe[NST-1].oqy;
          ostat <= pipe[NST-1].st;
        end else begin
          sx    <= pipe[NST-1].oqx;
          sy    <= pipe[NST-1].oqy;
          sstat <= pipe[NST-1].st;
        end
      end
    end else if (flows.ready) begin
      ox    <= sx;
      oy    <= sy;
      ostat <= sstat;
    end
  end

  assign flows.valid           = out_vld;
  assign flows.new_discharge_x = ox;
  assign flows.new_discharge_y = oy;
  assign flows.status          = ostat;

  `MFPI_ASSERT_IMP(a_skid_behind_out, skid_vld, out_vld, "skid holds an item with output empty")
  `MFPI_ASSERT_NXT(a_skid_fill, en && vld[NST-1] && out_vld && !flows.ready, skid_vld, "item lost at output")
  `MFPI_ASSERT_IMP(a_factor_range, vld[K_MAG-1] && pipe[K_MAG-1].st == mfpi_pkg::STAT_UPD, pipe[K_MAG-1].fx_q <= 33'h1_0000_0000, "friction factor above one")
  `MFPI_ASSERT_IMP(a_no_reversal, vld[K_OUT] && pipe[K_OUT].oqx != '0, pipe[K_OUT].oqx[31] == pipe[K_OUT].qx[31], "x discharge reversed")

endmodule

`default_nettype wire

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// Point-implicit Manning friction testbench
// Streams grid cells through the block under several register settings, with
// random gaps on the cell side and random stalls on the result side. Every
// result is compared with a bit-exact friction predictor or a typed value.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  typedef struct {
    logic [11:0] col;
    logic [11:0] row;
    logic [31:0] surf;
    logic [31:0] qx;
    logic [31:0] qy;
    logic [31:0] bed;
    logic [15:0] n;
  } cell_t;

  typedef struct {
    logic [31:0]     qx;
    logic [31:0]     qy;
    mfpi_pkg::stat_t st;
  } flow_t;

  typedef struct {
    cell_t           c;
    bit              typed;
    mfpi_pkg::stat_t st;
  } row_t;

  typedef struct {
    logic [31:0] ts;
    logic [15:0] lim;
    logic [12:0] cols;
    logic [12:0] rows;
    bit          idle;
    int          count;
  } phase_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        wr_en = 1'b0;
  logic [1:0]  wr_index = mfpi_pkg::REG_TIME_STEP;
  logic [31:0] wr_data = '0;

  mfpi_cell_if cells ();
  mfpi_flow_if flows ();

  manning_friction_point_implicit u_top (
    .clk      (clk),
    .rst      (rst),
    .cells    (cells.sink),
    .flows    (flows.source),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  logic [31:0] cfg_ts = 32'd0;
  logic [15:0] cfg_lim = mfpi_pkg::LIMIT_RESET;
  logic [12:0] cfg_cols = mfpi_pkg::DOMAIN_RESET;
  logic [12:0] cfg_rows = mfpi_pkg::DOMAIN_RESET;

  flow_t expected_flows[$];
  int    errors = 0;
  int    cells_sent = 0;
  int    flows_seen = 0;
  int    stat_count[4] = '{0, 0, 0, 0};
  bit    idle_on = 1'b0;
  int    stall_left = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    cells.valid = 1'b0;
    cells.cell_col = '0;
    cells.cell_row = '0;
    cells.surface_level = '0;
    cells.discharge_x = '0;
    cells.discharge_y = '0;
    cells.bed_level = '0;
    cells.manning_n = '0;
    flows.ready = 1'b0;
  end

  task automatic report(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic logic [63:0] isqrt(input logic [63:0] x);
    logic [63:0] r, c;
    r = '0;
    for (int b = 31; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (c * c <= x) r = c;
    end
    return r;
  endfunction

  function automatic logic [63:0] icbrt(input logic [63:0] x);
    logic [63:0] r, c;
    r = '0;
    for (int b = 20; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (c * c * c <= x) r = c;
    end
    return r;
  endfunction

  function automatic logic [63:0] flow_factor(input logic [63:0] w, input logic [63:0] q2,
                                              input logic [63:0] s);
    logic [127:0] rr, num, den, f;
    rr = ({64'd0, q2} << 32) / {64'd0, s};
    num = {64'd0, w} * {64'd0, rr[63:0]} + (128'd1 << 64);
    den = num + ({64'd0, w} << 32);
    f = (num << 32) / den;
    return f[63:0];
  endfunction

  function automatic logic [31:0] scale_flow(input logic [31:0] q, input logic [63:0] f);
    logic [63:0] mag, m;
    mag = q[31] ? 64'(-$signed(q)) : {32'd0, q};
    m = (mag * f) >> 32;
    return q[31] ? 32'(-m) : m[31:0];
  endfunction

  function automatic flow_t friction_update(input cell_t c);
    flow_t        o;
    logic [12:0]  cols, rows;
    logic signed [63:0] depth;
    logic [63:0]  ax, ay, s, qr, h, cb, t, w;
    logic [127:0] acc;
    o.qx = c.qx;
    o.qy = c.qy;
    cols = cfg_cols > mfpi_pkg::DOMAIN_RESET ? mfpi_pkg::DOMAIN_RESET : cfg_cols;
    rows = cfg_rows > mfpi_pkg::DOMAIN_RESET ? mfpi_pkg::DOMAIN_RESET : cfg_rows;
    depth = 64'($signed(c.surf)) - 64'($signed(c.bed));
    if (c.col == 0 || c.row == 0 || 13'(c.col) + 13'd1 >= cols ||
        13'(c.row) + 13'd1 >= rows || cfg_ts == 0) begin
      o.st = mfpi_pkg::STAT_SKIP;
      return o;
    end
    if (depth <= 0 || depth < $signed({48'd0, cfg_lim})) begin
      o.st = mfpi_pkg::STAT_DRY;
      return o;
    end
    ax = c.qx[31] ? 64'(-$signed(c.qx)) : {32'd0, c.qx};
    ay = c.qy[31] ? 64'(-$signed(c.qy)) : {32'd0, c.qy};
    s = ax * ax + ay * ay;
    qr = isqrt(s);
    if (s == 0 || qr < {48'd0, cfg_lim}) begin
      o.st = mfpi_pkg::STAT_STILL;
      return o;
    end
    h = 64'(depth);
    cb = icbrt(h << 29);
    t = ({48'd0, c.n} * {48'd0, c.n} * {44'd0, mfpi_pkg::GRAV_Q16}) >> 16;
    acc = {64'd0, {32'd0, cfg_ts} << 7} * {64'd0, t};
    acc = acc / {64'd0, h};
    acc = acc * {64'd0, qr};
    acc = acc / {64'd0, h};
    acc = acc / {64'd0, cb};
    w = (acc[127:63] != 0) ? 64'h7FFF_FFFF_FFFF_FFFF : acc[63:0];
    o.qx = scale_flow(c.qx, flow_factor(w, ax * ax, s));
    o.qy = scale_flow(c.qy, flow_factor(w, ay * ay, s));
    o.st = mfpi_pkg::STAT_UPD;
    return o;
  endfunction

  task automatic write_regs(input logic [31:0] ts, input logic [15:0] lim,
                            input logic [12:0] cols, input logic [12:0] rows);
    @(posedge clk);
    wr_en <= 1'b1;
    wr_index <= mfpi_pkg::REG_TIME_STEP;
    wr_data <= ts;
    @(posedge clk);
    wr_index <= mfpi_pkg::REG_SMALL_LIMIT;
    wr_data <= {16'd0, lim};
    @(posedge clk);
    wr_index <= mfpi_pkg::REG_GRID_COLS;
    wr_data <= {19'd0, cols};
    @(posedge clk);
    wr_index <= mfpi_pkg::REG_GRID_ROWS;
    wr_data <= {19'd0, rows};
    @(posedge clk);
    wr_en <= 1'b0;
    cfg_ts = ts;
    cfg_lim = lim;
    cfg_cols = cols;
    cfg_rows = rows;
  endtask

  task automatic send_cell(input cell_t c, input bit typed, input mfpi_pkg::stat_t st);
    int    gap;
    flow_t e;
    gap = idle_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      cells.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cells.valid <= 1'b1;
    cells.cell_col <= c.col;
    cells.cell_row <= c.row;
    cells.surface_level <= c.surf;
    cells.discharge_x <= c.qx;
    cells.discharge_y <= c.qy;
    cells.bed_level <= c.bed;
    cells.manning_n <= c.n;
    do @(posedge clk); while (!cells.ready);
    if (typed) begin
      e.qx = c.qx;
      e.qy = c.qy;
      e.st = st;
    end else begin
      e = friction_update(c);
    end
    expected_flows.push_back(e);
    cells_sent++;
  endtask

  task automatic drain();
    cells.valid <= 1'b0;
    while (expected_flows.size() != 0) @(posedge clk);
    repeat (160) @(posedge clk);
  endtask

  function automatic cell_t random_cell();
    cell_t c;
    int    lim_c, lim_r;
    lim_c = cfg_cols > mfpi_pkg::DOMAIN_RESET ? 4095 : (cfg_cols == 0 ? 0 : cfg_cols - 1);
    lim_r = cfg_rows > mfpi_pkg::DOMAIN_RESET ? 4095 : (cfg_rows == 0 ? 0 : cfg_rows - 1);
    if (lim_c > 4095) lim_c = 4095;
    if (lim_r > 4095) lim_r = 4095;
    c.col = ($urandom_range(0, 7) == 0) ? 12'($urandom) : 12'($urandom_range(0, lim_c));
    c.row = ($urandom_range(0, 7) == 0) ? 12'($urandom) : 12'($urandom_range(0, lim_r));
    c.bed = 32'($signed($urandom) >>> $urandom_range(0, 16));
    case ($urandom_range(0, 15))
      0: c.surf = c.bed;
      1: c.surf = $urandom;
      default: c.surf = c.bed + ($urandom >> $urandom_range(1, 31));
    endcase
    c.qx = 32'($signed($urandom) >>> $urandom_range(0, 31));
    c.qy = 32'($signed($urandom) >>> $urandom_range(0, 31));
    case ($urandom_range(0, 15))
      0: begin
        c.qx = '0;
        c.qy = '0;
      end
      1: c.qx = '0;
      2: c.qy = '0;
      default: ;
    endcase
    c.n = 16'($urandom >> $urandom_range(0, 16));
    return c;
  endfunction

  // result side: random stall after each taken result while idle_on is set
  always @(posedge clk) begin
    int s;
    if (rst) begin
      flows.ready <= 1'b0;
      stall_left = 0;
    end else begin
      s = stall_left;
      if (flows.valid && flows.ready) s = idle_on ? $urandom_range(0, 4) : 0;
      else if (s > 0) s--;
      stall_left = s;
      flows.ready <= (s == 0);
    end
  end

  always @(posedge clk) begin
    flow_t e;
    if (!rst && flows.valid && flows.ready) begin
      flows_seen++;
      stat_count[flows.status]++;
      if (expected_flows.size() == 0) begin
        report($sformatf("unexpected result qx=%h qy=%h st=%0d",
                         flows.new_discharge_x, flows.new_discharge_y, flows.status));
      end else begin
        e = expected_flows.pop_front();
        if (flows.status !== e.st)
          report($sformatf("status %0d, want %0d", flows.status, e.st));
        if (flows.new_discharge_x !== e.qx)
          report($sformatf("new_discharge_x %h, want %h", flows.new_discharge_x, e.qx));
        if (flows.new_discharge_y !== e.qy)
          report($sformatf("new_discharge_y %h, want %h", flows.new_discharge_y, e.qy));
      end
    end
  end

  initial begin
    #5ms;
    $display("manning_friction_point_implicit verification failed");
    $finish;
  end

  initial begin
    row_t   rows_at_reset[3];
    row_t   directed[12];
    phase_t phases[6];
    cell_t  c;

    rows_at_reset = '{
      '{'{12'd5, 12'd5, 32'h0002_0000, 32'h0001_0000, 32'hFFFF_8000, 32'h0, 16'h0A3D},
        1'b1, mfpi_pkg::STAT_SKIP},
      '{'{12'd4095, 12'd4095, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
          16'hFFFF}, 1'b1, mfpi_pkg::STAT_SKIP},
      '{'{12'd100, 12'd1, 32'h0000_0000, 32'h0, 32'h0, 32'h0, 16'h0}, 1'b1,
        mfpi_pkg::STAT_SKIP}
    };

    directed = '{
      '{'{12'd0, 12'd10, 32'h0002_0000, 32'h0001_0000, 32'h0001_0000, 32'h0, 16'h0A3D},
        1'b1, mfpi_pkg::STAT_SKIP},
      '{'{12'd10, 12'd0, 32'h0002_0000, 32'h0001_0000, 32'h0001_0000, 32'h0, 16'h0A3D},
        1'b1, mfpi_pkg::STAT_SKIP},
      '{'{12'd63, 12'd10, 32'h0002_0000, 32'h0001_0000, 32'h0001_0000, 32'h0, 16'h0A3D},
        1'b1, mfpi_pkg::STAT_SKIP},
      '{'{12'd10, 12'd63, 32'h0002_0000, 32'h0001_0000, 32'h0001_0000, 32'h0, 16'h0A3D},
        1'b1, mfpi_pkg::STAT_SKIP},
      '{'{12'd61, 12'd61, 32'h0002_0000, 32'h0001_0000, 32'hFFFF_8000, 32'h0, 16'h0A3D},
        1'b0, mfpi_pkg::STAT_UPD},
      '{'{12'd7, 12'd7, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
          16'h0A3D}, 1'b1, mfpi_pkg::STAT_DRY},
      '{'{12'd7, 12'd7, 32'h8000_0000, 32'h0001_0000, 32'h0, 32'h7FFF_FFFF, 16'h0A3D},
        1'b1, mfpi_pkg::STAT_DRY},
      '{'{12'd8, 12'd8, 32'h0001_0000, 32'h0, 32'h0, 32'h0, 16'hFFFF}, 1'b1,
        mfpi_pkg::STAT_STILL},
      '{'{12'd9, 12'd9, 32'h0003_0000, 32'h1234_5678, 32'hEDCB_A988, 32'h0, 16'h0},
        1'b1, mfpi_pkg::STAT_UPD},
      '{'{12'd9, 12'd9, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001,
          16'hFFFF}, 1'b0, mfpi_pkg::STAT_UPD},
      '{'{12'd1, 12'd1, 32'h0000_0001, 32'h0, 32'hFFF0_0000, 32'h0, 16'h8000},
        1'b0, mfpi_pkg::STAT_UPD},
      '{'{12'd20, 12'd30, 32'h0000_0100, 32'h0000_0010, 32'h0000_0001, 32'hFFFF_FF00,
          16'h0001}, 1'b0, mfpi_pkg::STAT_UPD}
    };

    phases = '{
      '{32'h0100_0000, 16'd1, 13'd4096, 13'd4096, 1'b1, 400},
      '{32'hFFFF_FFFF, 16'd0, 13'd64, 13'd64, 1'b1, 250},
      '{32'h0000_0001, 16'hFFFF, 13'd3, 13'd5, 1'b0, 120},
      '{32'h0040_0000, 16'd16, 13'd8191, 13'd100, 1'b1, 250},
      '{32'h0800_0000, 16'd256, 13'd0, 13'd4096, 1'b1, 60},
      '{32'h0000_1000, 16'd2, 13'd4096, 13'd1, 1'b0, 60}
    };

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows_at_reset[i])
      send_cell(rows_at_reset[i].c, rows_at_reset[i].typed, rows_at_reset[i].st);
    drain();

    write_regs(32'h0100_0000, 16'd1, 13'd64, 13'd64);
    idle_on = 1'b1;
    foreach (directed[i]) send_cell(directed[i].c, directed[i].typed, directed[i].st);
    drain();

    foreach (phases[p]) begin
      write_regs(phases[p].ts, phases[p].lim, phases[p].cols, phases[p].rows);
      idle_on = phases[p].idle;
      for (int k = 0; k < phases[p].count; k++) begin
        c = random_cell();
        send_cell(c, 1'b0, mfpi_pkg::STAT_UPD);
      end
      drain();
    end

    $display("Sent %0d cells over %0d register settings, %0d results checked.",
             cells_sent, 8, flows_seen);
    $display("Status mix: updated %0d, skipped %0d, dry %0d, still %0d.",
             stat_count[0], stat_count[1], stat_count[2], stat_count[3]);
    if (errors == 0 && expected_flows.size() == 0) begin
      $display("manning_friction_point_implicit verification clean");
    end else begin
      $display("manning_friction_point_implicit verification failed");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+sv
sv/mfpi_pkg.sv
sv/mfpi_if.sv
sv/manning_friction_point_implicit.sv
tb/testbench.sv
